// ===== src/audio_silence_detector_macros.svh =====
// Assertion macros used by the silence detector checker.
`ifndef AUDIO_SILENCE_DETECTOR_MACROS_SVH
`define AUDIO_SILENCE_DETECTOR_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next clock cycle.
`define ASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/asd_pkg.sv =====
// Types and constants of the audio silence detector.
package asd_pkg;

  // Largest block size that counts toward the loud allowance and the silent total
  localparam int unsigned MaxBlockBytes = 65536;
  localparam logic [16:0] MaxBlockClamp = 17'(MaxBlockBytes);

  // Loudness thresholds and allowance divisor
  localparam logic signed [15:0] LoudWide   = 16'sd327;
  localparam logic signed [7:0]  LoudNarrow = 8'sd2;
  localparam int unsigned        Percent    = 100;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    RegSeconds = 2'd0,
    RegWide    = 2'd1,
    RegRate    = 2'd2,
    RegStereo  = 2'd3
  } reg_idx_e;

  // Register reset values
  localparam logic [11:0] SecondsReset = 12'd0;
  localparam logic        WideReset    = 1'b1;
  localparam logic [17:0] RateReset    = 18'd44100;
  localparam logic        StereoReset  = 1'b1;

  // One input word
  typedef struct packed {
    logic signed [15:0] sample;
    logic [16:0]        block_bytes;
    logic               last_in_block;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic silence_detected;
    logic block_was_loud;
  } out_item_t;

  // Settings seen by the datapath
  typedef struct packed {
    logic        enabled;
    logic        wide;
    logic [31:0] limit;
  } core_cfg_t;

endpackage

// ===== src/asd_cfg.sv =====
// APB register file and silence limit of the audio silence detector.
module asd_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output asd_pkg::core_cfg_t cfg_o
);
  import asd_pkg::*;

  logic [11:0] seconds_q;
  logic        wide_q;
  logic [17:0] rate_q;
  logic        stereo_q;
  logic [31:0] limit_q, limit_d;
  logic [29:0] product;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= SecondsReset;
      wide_q    <= WideReset;
      rate_q    <= RateReset;
      stereo_q  <= StereoReset;
    end else if (wr_en) begin
      case (idx)
        RegSeconds: seconds_q <= pwdata[11:0];
        RegWide:    wide_q    <= pwdata[0];
        RegRate:    rate_q    <= pwdata[17:0];
        RegStereo:  stereo_q  <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegSeconds: prdata = {20'd0, seconds_q};
      RegWide:    prdata = {31'd0, wide_q};
      RegRate:    prdata = {14'd0, rate_q};
      RegStereo:  prdata = {31'd0, stereo_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Form limit: seconds * rate, doubled for wide samples and for stereo
  assign product = 30'(seconds_q) * 30'(rate_q);

  always_comb begin
    case ({wide_q, stereo_q})
      2'b00:   limit_d = {2'b00, product};
      2'b11:   limit_d = {product, 2'b00};
      default: limit_d = {1'b0, product, 1'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 32'd0;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign cfg_o.enabled = (seconds_q != 12'd0);
  assign cfg_o.wide    = wide_q;
  assign cfg_o.limit   = limit_q;

endmodule

// ===== src/asd_core.sv =====
// Input register, block state and result register of the silence detector.
module asd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  asd_pkg::core_cfg_t cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  asd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output asd_pkg::out_item_t out_data_o
);
  import asd_pkg::*;

  in_item_t    item_q;
  logic        item_valid_q;
  out_item_t   res_q, res_d;
  logic        res_valid_q;
  logic [15:0] loud_count_q, loud_count_d;
  logic        block_loud_q, block_loud_d;
  logic [31:0] silent_bytes_q, silent_bytes_d;

  logic        advance;
  logic        load_res;
  logic [16:0] bb_c;
  logic [16:0] allow_base;
  logic        is_loud;
  logic        hit;
  logic [15:0] lc_inc;
  logic [22:0] lc_x100;
  logic        exceed;
  logic        bl_mid;
  logic [31:0] sb_mid;
  logic [32:0] sum;
  logic [31:0] sb_sum;
  logic        silent;
  logic signed [7:0] narrow;

  // Move the held word on unless its result is blocked
  assign advance    = item_valid_q & (~item_q.last_in_block | ~res_valid_q | out_ready_i);
  assign load_res   = advance & item_q.last_in_block;
  assign in_ready_o = ~item_valid_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  // Clamp block size and pick the allowance base
  assign bb_c       = (item_q.block_bytes > MaxBlockClamp) ? MaxBlockClamp : item_q.block_bytes;
  assign allow_base = cfg_i.wide ? {1'b0, bb_c[16:1]} : bb_c;

  // Judge the sample
  assign narrow  = item_q.sample[7:0];
  assign is_loud = cfg_i.wide ?
                   (item_q.sample >= LoudWide || item_q.sample <= -LoudWide) :
                   (narrow >= LoudNarrow || narrow <= -LoudNarrow);
  assign hit     = cfg_i.enabled & ~block_loud_q & is_loud;

  // Count loud samples; count > floor(base/100) holds exactly when 100*count > base
  assign lc_inc  = (hit && loud_count_q != 16'hFFFF) ? loud_count_q + 16'd1 : loud_count_q;
  assign lc_x100 = 23'(lc_inc) * 23'(Percent);
  assign exceed  = hit & (lc_x100 > {6'd0, allow_base});
  assign bl_mid  = block_loud_q | exceed;
  assign sb_mid  = exceed ? 32'd0 : silent_bytes_q;

  // Add a quiet block to the total, saturating
  assign sum    = {1'b0, sb_mid} + {16'd0, bb_c};
  assign sb_sum = (cfg_i.enabled && !bl_mid) ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) : sb_mid;
  assign silent = cfg_i.enabled & (sb_sum >= cfg_i.limit);

  // Next block state
  always_comb begin
    loud_count_d   = loud_count_q;
    block_loud_d   = block_loud_q;
    silent_bytes_d = silent_bytes_q;
    res_d.silence_detected = silent;
    res_d.block_was_loud   = cfg_i.enabled & bl_mid;
    if (advance) begin
      if (item_q.last_in_block) begin
        loud_count_d   = 16'd0;
        block_loud_d   = 1'b0;
        silent_bytes_d = silent ? 32'd0 : sb_sum;
      end else begin
        loud_count_d   = lc_inc;
        block_loud_d   = bl_mid;
        silent_bytes_d = sb_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loud_count_q   <= 16'd0;
      block_loud_q   <= 1'b0;
      silent_bytes_q <= 32'd0;
    end else begin
      loud_count_q   <= loud_count_d;
      block_loud_q   <= block_loud_d;
      silent_bytes_q <= silent_bytes_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== src/audio_silence_detector.sv =====
// Audio silence detector top level.
// Takes one sample word per clock cycle unless a block end waits behind a
// stalled result. A sample goes into an input register and is judged and folded
// into the block state as it leaves that register; the word that ends a block
// leaves its result in the output register, so a result passes the input
// register and then the output register; words without the end-of-block mark
// give no result. The output register holds a waiting result while further
// samples keep flowing; only a block end behind a stalled result waits.
// The silence limit (seconds * rate, times two for 16-bit samples and for stereo)
// is formed by one multiplier into a register, valid the cycle after a register write.
module audio_silence_detector (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  asd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output asd_pkg::out_item_t out_data_o
);
  import asd_pkg::*;

  core_cfg_t cfg;

  // Configuration registers and limit
  asd_cfg u_asd_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sample datapath
  asd_core u_asd_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/asd_checker.sv =====
// Port checker of the audio silence detector and its bind.
`include "audio_silence_detector_macros.svh"

module asd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input asd_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input asd_pkg::out_item_t out_data_o
);
  import asd_pkg::*;

  // Hold a stalled result word
  `ASD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word dropped or changed while stalled")

  // Accept input whenever no result is waiting
  `ASD_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  // A fresh result follows an accepted block-end word
  `ASD_ASSERT(a_result_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.last_in_block, 2), "result without a matching block end")

endmodule

bind audio_silence_detector asd_checker u_asd_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the audio silence detector: scoreboard class, drivers and checks.
package tb_silence_pkg;
  import asd_pkg::*;

  // Track the silent-byte total across blocks and keep the verdicts still owed
  class silence_scoreboard;
    logic [11:0] seconds;
    logic        wide;
    logic [17:0] rate;
    logic        stereo;
    logic [31:0] limit;
    logic [15:0] loud_count;
    logic        block_loud;
    logic [31:0] silent_bytes;
    out_item_t   pending_verdicts[$];
    int          errors;
    int          verdicts;
    int          silences;
    int          loud_blocks;

    function new();
      seconds      = SecondsReset;
      wide         = WideReset;
      rate         = RateReset;
      stereo       = StereoReset;
      loud_count   = '0;
      block_loud   = 1'b0;
      silent_bytes = '0;
      errors       = 0;
      verdicts     = 0;
      silences     = 0;
      loud_blocks  = 0;
      update_limit();
    endfunction

    // Rebuild the byte limit: seconds * bytes per sample * rate * channels, saturated
    function void update_limit();
      longint unsigned v;
      v = seconds;
      v = v * (wide ? 64'd2 : 64'd1) * rate;
      if (stereo) v = v * 2;
      limit = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        RegSeconds: seconds = v[11:0];
        RegWide:    wide    = v[0];
        RegRate:    rate    = v[17:0];
        RegStereo:  stereo  = v[0];
        default: ;
      endcase
      update_limit();
    endfunction

    // Fold one accepted word into the block state; a block end owes one verdict
    function void note_word(in_item_t w);
      logic [16:0]       bytes;
      logic signed [7:0] low_byte;
      logic [32:0]       sum;
      logic              enabled;
      logic              flagged;
      logic              loud;
      int                level;
      int                magnitude;
      int                threshold;
      int                allowance;
      out_item_t         verdict;
      bytes   = (w.block_bytes > MaxBlockClamp) ? MaxBlockClamp : w.block_bytes;
      enabled = (seconds != '0);
      if (enabled && !block_loud) begin
        low_byte  = w.sample[7:0];
        level     = wide ? int'(w.sample) : int'(low_byte);
        magnitude = (level < 0) ? -level : level;
        threshold = wide ? int'(LoudWide) : int'(LoudNarrow);
        allowance = wide ? int'((bytes / 2) / Percent) : int'(bytes / Percent);
        if (magnitude >= threshold) begin
          if (loud_count != 16'hFFFF) loud_count++;
          // past the allowance the block is loud and the total restarts
          if (int'(loud_count) > allowance) begin
            block_loud   = 1'b1;
            silent_bytes = '0;
          end
        end
      end
      if (!w.last_in_block) return;
      loud    = enabled && block_loud;
      flagged = 1'b0;
      if (enabled) begin
        if (!block_loud) begin
          sum          = {1'b0, silent_bytes} + 33'(bytes);
          silent_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        if (silent_bytes >= limit) begin
          flagged      = 1'b1;
          silent_bytes = '0;
        end
      end
      loud_count = '0;
      block_loud = 1'b0;
      verdict.silence_detected = flagged;
      verdict.block_was_loud   = loud;
      pending_verdicts.push_back(verdict);
    endfunction

    // Compare one result word with the oldest verdict owed
    function void check_verdict(out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word: silence_detected %0b block_was_loud %0b",
               got.silence_detected, got.block_was_loud);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts++;
      if (want.silence_detected) silences++;
      if (want.block_was_loud) loud_blocks++;
      if (got.silence_detected !== want.silence_detected) begin
        $error("silence_detected: expected %0b, got %0b",
               want.silence_detected, got.silence_detected);
        errors++;
      end
      if (got.block_was_loud !== want.block_was_loud) begin
        $error("block_was_loud: expected %0b, got %0b",
               want.block_was_loud, got.block_was_loud);
        errors++;
      end
    endfunction
  endclass

endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asd_pkg::*;
  import tb_silence_pkg::*;

  localparam int ItemsTarget = 1900;
  localparam int QuietTail   = 250;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 6;
  localparam int StallLimit  = 2000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  silence_scoreboard sb;
  int words_sent  = 0;
  int setups      = 0;
  int quiet_cycles = 0;
  bit idle_on     = 1'b0;
  bit hold_req    = 1'b0;

  audio_silence_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idling is off in stretches and for the tail of the run
  function automatic bit idling_allowed();
    return idle_on && (words_sent < ItemsTarget - QuietTail);
  endfunction

  // Check result words and watch for a stuck handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_verdict(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[audio_silence_detector] ERROR");
        $finish;
      end
    end
  end

  // Drive the result side: random stalls, one long hold-off on request
  initial begin : receiver
    wait (rst_ni == 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idling_allowed() && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offer one word and hold it until it is taken
  task automatic send_word(logic signed [15:0] s, logic [16:0] b, logic last);
    in_item_t w;
    w.sample        = s;
    w.block_bytes   = b;
    w.last_in_block = last;
    if (idling_allowed() && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  // Drop valid, wait for every owed verdict, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [11:0] secs, logic wide, logic [17:0] rate, logic stereo);
    settle();
    write_reg(RegSeconds, 32'(secs));
    write_reg(RegWide, 32'(wide));
    write_reg(RegRate, 32'(rate));
    write_reg(RegStereo, 32'(stereo));
    setups++;
    // the limit register is loaded in the cycle after the write
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [16:0] pick_bytes();
    case ($urandom_range(0, 9))
      0, 1, 2: return 17'($urandom_range(0, 600));
      3, 4, 5: return 17'($urandom_range(601, 3000));
      6:       return 17'($urandom_range(65536, 131071));
      7:       return 17'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0:       return 17'd0;
          1:       return 17'd65535;
          2:       return 17'd65536;
          default: return 17'd65537;
        endcase
      end
      default: return 17'($urandom_range(3001, 65535));
    endcase
  endfunction

  // Pick a sample around the loudness threshold of the current mode
  function automatic logic signed [15:0] pick_sample(bit wide, bit loud);
    logic signed [15:0] s;
    logic [7:0]         low;
    int                 m;
    if ($urandom_range(0, 15) == 0) return 16'($urandom);
    if (wide) begin
      case ($urandom_range(0, 3))
        0:       m = loud ? 327 : 326;
        1:       m = loud ? 32767 : 0;
        default: m = loud ? $urandom_range(327, 32767) : $urandom_range(0, 326);
      endcase
      s = 16'(m);
      if ($urandom_range(0, 1)) s = -s;
      if (loud && $urandom_range(0, 15) == 0) s = 16'sh8000;
      return s;
    end
    case ($urandom_range(0, 3))
      0:       m = loud ? 2 : 1;
      1:       m = loud ? 127 : 0;
      default: m = loud ? $urandom_range(2, 127) : $urandom_range(0, 1);
    endcase
    low = 8'(m);
    if ($urandom_range(0, 1)) low = -low;
    if (loud && $urandom_range(0, 15) == 0) low = 8'h80;
    // upper byte is ignored in 8-bit mode, so fill it with noise
    return {8'($urandom), low};
  endfunction

  // Send one block of random length and loudness; a few get ragged byte sizes
  task automatic send_block();
    int          n;
    int          loud_pct;
    bit          ragged;
    logic [16:0] bytes;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
    case ($urandom_range(0, 3))
      0:       loud_pct = 0;
      1:       loud_pct = 3;
      2:       loud_pct = 30;
      default: loud_pct = 90;
    endcase
    bytes  = pick_bytes();
    ragged = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      send_word(pick_sample(sb.wide, $urandom_range(1, 100) <= loud_pct),
                ragged ? pick_bytes() : bytes, i == n - 1);
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_end;
    logic [11:0] secs;
    logic [17:0] rate;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Detection off after reset: loud words change nothing, verdict is all zero
    send_word(16'sh8000, 17'd65536, 1'b0);
    send_word(16'sh7FFF, 17'd65536, 1'b1);

    // 16-bit mono, limit 200 bytes: threshold edges, clamped size, allowance of zero
    configure(12'd1, 1'b1, 18'd100, 1'b0);
    send_word(16'sd326, 17'd100, 1'b1);
    send_word(-16'sd326, 17'h1FFFF, 1'b1);
    send_word(16'sd327, 17'd0, 1'b0);
    send_word(16'sd0, 17'd0, 1'b1);
    send_word(-16'sd327, 17'd200, 1'b0);
    send_word(16'sh8000, 17'd200, 1'b0);
    send_word(16'sh7FFF, 17'd200, 1'b1);

    // 8-bit stereo at the largest seconds and a 192000 rate: only the low byte counts
    configure(12'hFFF, 1'b0, 18'd192000, 1'b1);
    send_word(16'sh7F02, 17'd100, 1'b0);
    send_word(16'sh00FE, 17'd100, 1'b0);
    send_word(16'sh8001, 17'd100, 1'b1);
    send_word(16'shFF7F, 17'd99, 1'b0);
    send_word(16'sh0180, 17'd99, 1'b1);
    send_word(16'shFFFF, 17'd65535, 1'b1);

    // Zero rate: every enabled block end flags silence
    configure(12'hFFF, 1'b0, 18'd0, 1'b1);
    send_word(16'sd0, 17'd0, 1'b1);
    send_word(16'sh5555, 17'h0AAAA, 1'b1);
    send_word(16'shAAAA, 17'h15555, 1'b1);

    // Widest rate field
    configure(12'hFFF, 1'b1, 18'h3FFFF, 1'b1);
    send_word(16'sd0, 17'h1FFFF, 1'b1);

    // Random phases, each under a fresh register setup
    phase = 0;
    while (words_sent < ItemsTarget) begin
      idle_on = (phase % 4 != 3);
      case ($urandom_range(0, 9))
        0:       secs = 12'd0;
        1:       secs = 12'hFFF;
        default: secs = 12'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 9))
        0:       rate = 18'd0;
        1:       rate = 18'd192000;
        2:       rate = 18'h3FFFF;
        3:       rate = 18'd44100;
        4:       rate = 18'd1;
        default: rate = 18'($urandom_range(1, 400));
      endcase
      configure(secs, 1'($urandom_range(0, 1)), rate, 1'($urandom_range(0, 1)));
      if (phase == 2) begin
        // hold the result side off while block ends keep coming
        hold_req = 1'b1;
        repeat (24) send_word(pick_sample(sb.wide, $urandom_range(0, 1)), pick_bytes(), 1'b1);
      end
      phase_end = words_sent + $urandom_range(80, 200);
      while (words_sent < phase_end && words_sent < ItemsTarget) send_block();
      phase++;
    end
    settle();

    $display("Sent %0d sample words under %0d register setups.", words_sent, setups);
    $display("Checked %0d block verdicts: %0d silence flags, %0d loud blocks.",
             sb.verdicts, sb.silences, sb.loud_blocks);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("[audio_silence_detector] OK");
    end else begin
      $display("[audio_silence_detector] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/asd_pkg.sv
src/asd_cfg.sv
src/asd_core.sv
src/audio_silence_detector.sv
src/asd_checker.sv
test/tb_top.sv
